// ===== rtl/mpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the multilevel priority queue.
// No dependencies; used by the controller, datapath and top level.
package mpq_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned OpW     = 2;
  localparam int unsigned PrioW   = 4;
  localparam int unsigned HandleW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TopW    = 5;

  typedef enum logic [OpW-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // record the result status, update level state, start memory access
    logic finish;  // refresh the top level and load the output register
  } cmd_t;

endpackage

// ===== rtl/multilevel_priority_fifo_queue.sv =====
`timescale 1ns / 1ps
// Multilevel priority FIFO queue: LEVELS FIFOs of handles, level 0 highest.
// Each item is accepted in the idle state and finished in the following state,
// which waits while the previous result still sits in the output register.
// A new item is taken only after the previous one is finished: the finish state
// covers the registered read of the handle store and the top-level re-encode.
// Reset (rst_ni low, asynchronous) empties every level and sets top to LEVELS;
// the handle store is not cleared, so the block accepts items right after reset.
module multilevel_priority_fifo_queue #(
  parameter int unsigned LEVELS          = 16,
  parameter int unsigned DEPTH_PER_LEVEL = 16,
  parameter int unsigned HANDLE_BITS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mpq_pkg::OpW-1:0]             op_i,
  input  logic [mpq_pkg::PrioW-1:0]           priority_req_i,
  input  logic [mpq_pkg::HandleW-1:0]         handle_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mpq_pkg::StatusW-1:0]         status_o,
  output logic                                got_item_o,
  output logic [mpq_pkg::HandleW-1:0]         out_handle_o,
  output logic [mpq_pkg::TopW-1:0]            top_level_o
);

  mpq_pkg::cmd_t cmd;

  // The controller takes an item whenever it is idle, even while the previous
  // result still sits in the output register; it then waits in its finish
  // state until that register drains before loading the new result.
  mpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // On accept the datapath appends to or pops from the selected level and
  // issues the store access; on finish it re-encodes the top level and loads
  // the result fields.
  mpq_dp #(
    .LEVELS          (LEVELS),
    .DEPTH_PER_LEVEL (DEPTH_PER_LEVEL),
    .HANDLE_BITS     (HANDLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .handle_i       (handle_i),
    .status_o       (status_o),
    .got_item_o     (got_item_o),
    .out_handle_o   (out_handle_o),
    .top_level_o    (top_level_o)
  );

endmodule

// ===== rtl/mpq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module mpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mpq_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller: accepts one item, finishes it, owns the output valid.
// Depends on mpq_pkg.
module mpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mpq_pkg::cmd_t cmd_o
);

  mpq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign in_ready_o = (state_q == mpq_pkg::S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.finish  = 1'b0;
    case (state_q)
      mpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = mpq_pkg::S_DONE;
        end
      end
      mpq_pkg::S_DONE: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = mpq_pkg::S_IDLE;
        end
      end
      default: state_d = mpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mpq_dp.sv =====
`timescale 1ns / 1ps
// Datapath: per-level head/tail/count registers, handle store, top-level encoder
// and the output register. Depends on mpq_pkg and mpq_ram.
module mpq_dp #(
  parameter int unsigned LEVELS          = 16,
  parameter int unsigned DEPTH_PER_LEVEL = 16,
  parameter int unsigned HANDLE_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpq_pkg::cmd_t                 cmd_i,
  input  logic [mpq_pkg::OpW-1:0]       op_i,
  input  logic [mpq_pkg::PrioW-1:0]     priority_req_i,
  input  logic [mpq_pkg::HandleW-1:0]   handle_i,
  output logic [mpq_pkg::StatusW-1:0]   status_o,
  output logic                          got_item_o,
  output logic [mpq_pkg::HandleW-1:0]   out_handle_o,
  output logic [mpq_pkg::TopW-1:0]      top_level_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned TW = $clog2(LEVELS + 1);
  localparam int unsigned PW = $clog2(DEPTH_PER_LEVEL);
  localparam int unsigned CW = $clog2(DEPTH_PER_LEVEL + 1);
  localparam int unsigned RamDepth = LEVELS * (2 ** PW);

  logic [PW-1:0] head_q  [LEVELS];
  logic [PW-1:0] tail_q  [LEVELS];
  logic [CW-1:0] count_q [LEVELS];
  logic [TW-1:0] top_q;

  logic [mpq_pkg::StatusW-1:0] res_status_q;
  logic                        res_got_q;
  logic [mpq_pkg::StatusW-1:0] status_q;
  logic                        got_q;
  logic [mpq_pkg::HandleW-1:0] handle_q;
  logic [mpq_pkg::TopW-1:0]    top_out_q;

  mpq_pkg::op_e        op;
  logic                prio_sat;
  logic [LW-1:0]       enq_lv;
  logic [LW-1:0]       sel_lv;
  logic [CW-1:0]       sel_count;
  logic                queue_empty;
  logic                level_full;
  logic                do_write;
  logic                do_read;
  logic [PW-1:0]       sel_pos;
  logic [PW-1:0]       next_pos;
  logic [63:0]         hnd_ext;
  logic [63:0]         rd_ext;
  logic [63:0]         top_ext;
  logic [HANDLE_BITS-1:0] rdata;
  logic [TW-1:0]       enc_top;
  logic [mpq_pkg::StatusW-1:0] res_status;

  assign op          = mpq_pkg::op_e'(op_i);
  assign prio_sat    = (32'(priority_req_i) >= 32'(LEVELS));
  assign enq_lv      = prio_sat ? LW'(LEVELS - 1) : LW'(priority_req_i);
  assign queue_empty = (top_q == TW'(LEVELS));
  assign sel_lv      = (op == mpq_pkg::OP_DEQ) ? top_q[LW-1:0] : enq_lv;
  assign sel_count   = count_q[sel_lv];
  assign level_full  = (sel_count == CW'(DEPTH_PER_LEVEL));
  assign sel_pos     = (op == mpq_pkg::OP_DEQ) ? head_q[sel_lv] : tail_q[sel_lv];
  assign next_pos    = (sel_pos == PW'(DEPTH_PER_LEVEL - 1)) ? '0 : sel_pos + 1'b1;
  assign hnd_ext     = 64'(handle_i);

  always_comb begin
    do_write   = 1'b0;
    do_read    = 1'b0;
    res_status = mpq_pkg::ST_OK;
    case (op)
      mpq_pkg::OP_ENQ: begin
        if (level_full) begin
          res_status = mpq_pkg::ST_FULL;
        end else begin
          do_write = cmd_i.accept;
        end
      end
      mpq_pkg::OP_DEQ: begin
        if (queue_empty || sel_count == '0) begin
          res_status = mpq_pkg::ST_EMPTY;
        end else begin
          do_read = cmd_i.accept;
        end
      end
      default: res_status = mpq_pkg::ST_OK;  // peek and the unused code change nothing
    endcase
  end

  mpq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .re_i    (do_read),
    .addr_i  ({sel_lv, sel_pos}),
    .wdata_i (hnd_ext[HANDLE_BITS-1:0]),
    .rdata_o (rdata)
  );

  // Highest-priority nonempty level, LEVELS when all are empty
  always_comb begin
    enc_top = TW'(LEVELS);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        enc_top = TW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
      top_q <= TW'(LEVELS);
    end else begin
      if (do_write) begin
        tail_q[sel_lv]  <= next_pos;
        count_q[sel_lv] <= sel_count + 1'b1;
      end
      if (do_read) begin
        head_q[sel_lv]  <= next_pos;
        count_q[sel_lv] <= sel_count - 1'b1;
      end
      if (cmd_i.finish) begin
        top_q <= enc_top;
      end
    end
  end

  assign rd_ext  = 64'(rdata);
  assign top_ext = 64'(enc_top);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= res_status;
      res_got_q    <= do_read;
    end
    if (cmd_i.finish) begin
      status_q  <= res_status_q;
      got_q     <= res_got_q;
      handle_q  <= res_got_q ? rd_ext[mpq_pkg::HandleW-1:0] : '0;
      top_out_q <= top_ext[mpq_pkg::TopW-1:0];
    end
  end

  assign status_o     = status_q;
  assign got_item_o   = got_q;
  assign out_handle_o = handle_q;
  assign top_level_o  = top_out_q;

endmodule

// ===== rtl/mpq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the multilevel priority queue, bound to the top level.
// Depends on mpq_pkg.
module mpq_checker #(
  parameter int unsigned LEVELS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [mpq_pkg::StatusW-1:0]       status_o,
  input logic                              got_item_o,
  input logic [mpq_pkg::HandleW-1:0]       out_handle_o,
  input logic [mpq_pkg::TopW-1:0]          top_level_o
);

  localparam logic [mpq_pkg::TopW-1:0] EmptyTop = mpq_pkg::TopW'(LEVELS);

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_handle_o) && $stable(top_level_o))
    else $error("result changed while stalled");

  a_one_per_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted in back-to-back cycles");

  a_got_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && got_item_o |-> status_o == mpq_pkg::ST_OK
      && top_level_o <= EmptyTop)
    else $error("handle returned with error status");

  a_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !got_item_o |-> out_handle_o == '0)
    else $error("handle nonzero without a dequeue");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mpq_pkg::ST_EMPTY |-> top_level_o == EmptyTop
      && !got_item_o)
    else $error("empty dequeue reported a nonempty queue");

endmodule

bind multilevel_priority_fifo_queue mpq_checker #(
  .LEVELS (LEVELS)
) u_mpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .got_item_o   (got_item_o),
  .out_handle_o (out_handle_o),
  .top_level_o  (top_level_o)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multilevel_priority_fifo_queue: a queued driver, a monitor
// and a cycle-free model of the sixteen level FIFOs. Depends on mpq_pkg and the RTL.
module tb;

  localparam int unsigned Levels = 16;
  localparam int unsigned Depth  = 16;
  localparam int unsigned Tail   = 20;   // settle cycles after the last result
  localparam logic [mpq_pkg::OpW-1:0] OpUnused = 2'd3;
  localparam logic [mpq_pkg::TopW-1:0] TopEmpty = 5'd16;

  typedef struct {
    logic [mpq_pkg::OpW-1:0]     op;
    logic [mpq_pkg::PrioW-1:0]   prio;
    logic [mpq_pkg::HandleW-1:0] hnd;
  } queue_req_t;

  typedef struct {
    mpq_pkg::status_e            status;
    logic                        got;
    logic [mpq_pkg::HandleW-1:0] hnd;
    logic [mpq_pkg::TopW-1:0]    top;
  } queue_rsp_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic [mpq_pkg::OpW-1:0]     op_i           = mpq_pkg::OP_PEEK;
  logic [mpq_pkg::PrioW-1:0]   priority_req_i = '0;
  logic [mpq_pkg::HandleW-1:0] handle_i       = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [mpq_pkg::StatusW-1:0] status_o;
  logic                        got_item_o;
  logic [mpq_pkg::HandleW-1:0] out_handle_o;
  logic [mpq_pkg::TopW-1:0]    top_level_o;

  multilevel_priority_fifo_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .handle_i       (handle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .got_item_o     (got_item_o),
    .out_handle_o   (out_handle_o),
    .top_level_o    (top_level_o)
  );

  // Items waiting to be driven, and results the block still owes us.
  queue_req_t pending_items[$];
  queue_rsp_t owed_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int n_accepted     = 0;
  int n_checked      = 0;
  int n_popped       = 0;
  int n_refused      = 0;
  int n_empty_deq    = 0;

  // Shadow copy of the level FIFOs.
  logic [mpq_pkg::HandleW-1:0] shadow_store [Levels][Depth];
  logic [3:0]                  shadow_head  [Levels];
  logic [3:0]                  shadow_tail  [Levels];
  logic [4:0]                  shadow_count [Levels];
  logic [mpq_pkg::TopW-1:0]    shadow_top;

  initial begin
    for (int lv = 0; lv < Levels; lv++) begin
      shadow_head[lv]  = '0;
      shadow_tail[lv]  = '0;
      shadow_count[lv] = '0;
    end
    shadow_top = TopEmpty;
  end

  // Apply one item to the shadow state and return the result it must produce.
  function automatic queue_rsp_t queue_predict(input queue_req_t req);
    queue_rsp_t rsp;
    int lv;
    rsp.status = mpq_pkg::ST_OK;
    rsp.got    = 1'b0;
    rsp.hnd    = '0;
    lv         = int'(req.prio);
    case (req.op)
      mpq_pkg::OP_ENQ: begin
        if (shadow_count[lv] == Depth) begin
          // level full: drop the handle
          rsp.status = mpq_pkg::ST_FULL;
          n_refused++;
        end else begin
          shadow_store[lv][shadow_tail[lv]] = req.hnd;
          shadow_tail[lv]  = shadow_tail[lv] + 4'd1;
          shadow_count[lv] = shadow_count[lv] + 5'd1;
          if (lv < int'(shadow_top)) shadow_top = mpq_pkg::TopW'(lv);
        end
      end
      mpq_pkg::OP_DEQ: begin
        if (shadow_top == TopEmpty) begin
          rsp.status = mpq_pkg::ST_EMPTY;
          n_empty_deq++;
        end else begin
          lv = int'(shadow_top);
          rsp.got  = 1'b1;
          rsp.hnd  = shadow_store[lv][shadow_head[lv]];
          shadow_head[lv]  = shadow_head[lv] + 4'd1;
          shadow_count[lv] = shadow_count[lv] - 5'd1;
          n_popped++;
          // re-encode the highest nonempty level
          shadow_top = TopEmpty;
          for (int k = Levels - 1; k >= 0; k--) begin
            if (shadow_count[k] != 0) shadow_top = mpq_pkg::TopW'(k);
          end
        end
      end
      default: begin
        // peek and the unused code change nothing
      end
    endcase
    rsp.top = shadow_top;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("MISMATCH result %0d %s: got %0h expected %0h", n_checked, what, got, want);
  endtask

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Driver: hold the item until accepted, then advance or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    queue_req_t nxt;
    queue_req_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur.op   = op_i;
        cur.prio = priority_req_i;
        cur.hnd  = handle_i;
        owed_results.push_back(queue_predict(cur));
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid_i     <= 1'b1;
          op_i           <= nxt.op;
          priority_req_i <= nxt.prio;
          handle_i       <= nxt.hnd;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest owed one.
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    queue_rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result, top_level", 32'(top_level_o), 32'd0);
        end else begin
          want = owed_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (got_item_o !== want.got)
            report_mismatch("got_item", 32'(got_item_o), 32'(want.got));
          if (out_handle_o !== want.hnd)
            report_mismatch("out_handle", 32'(out_handle_o), 32'(want.hnd));
          if (top_level_o !== want.top)
            report_mismatch("top_level", 32'(top_level_o), 32'(want.top));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_item(input logic [mpq_pkg::OpW-1:0] op, input int prio, input int hnd);
    queue_req_t it;
    it.op   = op;
    it.prio = mpq_pkg::PrioW'(prio);
    it.hnd  = mpq_pkg::HandleW'(hnd);
    pending_items.push_back(it);
  endtask

  // Bursts that lean toward filling or draining or stay balanced, most enqueues aimed at one
  // hot level so that levels run full as well as empty.
  task automatic add_random_items(input int count);
    int enq_pct;
    int burst;
    int hot;
    int r;
    int prio;
    int hnd;
    while (count > 0) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 75;
        1:       enq_pct = 25;
        default: enq_pct = 50;
      endcase
      burst = $urandom_range(20, 50);
      hot   = $urandom_range(0, Levels - 1);
      for (int k = 0; k < burst && count > 0; k++) begin
        r    = $urandom_range(0, 99);
        prio = ($urandom_range(0, 99) < 70) ? hot : $urandom_range(0, Levels - 1);
        case ($urandom_range(0, 9))
          0:       hnd = 0;
          1:       hnd = 16'hFFFF;
          default: hnd = $urandom_range(0, 16'hFFFF);
        endcase
        if (r < 3)                      push_item(OpUnused, prio, hnd);
        else if (r < 8)                 push_item(mpq_pkg::OP_PEEK, prio, hnd);
        else if (r < 8 + enq_pct * 92 / 100) push_item(mpq_pkg::OP_ENQ, prio, hnd);
        else                            push_item(mpq_pkg::OP_DEQ, prio, hnd);
        count--;
      end
    end
  endtask

  // Wait until every queued item went in and every result came back.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("multilevel_priority_fifo_queue verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty queue cases, extremes, unused op, then run one level full.
    push_item(mpq_pkg::OP_PEEK, 0, 0);
    push_item(mpq_pkg::OP_DEQ, 15, 16'hFFFF);
    push_item(OpUnused, 15, 16'hFFFF);
    push_item(mpq_pkg::OP_ENQ, 15, 16'hFFFF);
    push_item(mpq_pkg::OP_ENQ, 0, 0);
    push_item(mpq_pkg::OP_ENQ, 5, 16'hAAAA);
    push_item(mpq_pkg::OP_PEEK, 0, 0);
    push_item(mpq_pkg::OP_DEQ, 0, 0);
    push_item(OpUnused, 0, 16'h5555);
    for (int k = 0; k < Depth + 1; k++)
      push_item(mpq_pkg::OP_ENQ, 7, 16'h0700 + k);

    // Phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  <= (ph == 1) ? 69 : (ph == 3) ? 12 : 0;
      recv_stall_pct <= (ph == 2) ? 69 : (ph == 3) ? 12 : 0;
      add_random_items(288);
      // hold off the sender until everything owed has come back
      wait_drained();
    end

    repeat (Tail) @(negedge clk_i);
    if (owed_results.size() != 0)
      report_mismatch("results never delivered", 32'(owed_results.size()), 32'd0);

    $display("Covered %0d items and %0d results: %0d handles dequeued,", n_accepted,
             n_checked, n_popped);
    $display("%0d enqueues refused on a full level, %0d dequeues on an empty queue.",
             n_refused, n_empty_deq);
    if (mismatches == 0) begin
      $display("multilevel_priority_fifo_queue verification clean");
    end else begin
      $display("multilevel_priority_fifo_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mpq_pkg.sv
rtl/mpq_ram.sv
rtl/mpq_ctrl.sv
rtl/mpq_dp.sv
rtl/multilevel_priority_fifo_queue.sv
rtl/mpq_checker.sv
test/tb.sv
